// ----- hdl/spsq_pkg.sv -----
// shared types and constants for the shared pool stack and queue manager
// used by spsq_lists and shared_pool_stack_queue_manager; no dependencies
package spsq_pkg;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_ENQ  = 2'd2,
    OP_DEQ  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  localparam int unsigned ITEM_BITS = 32;
  localparam int unsigned SLOT_OUT_BITS = 4;

  typedef struct packed {
    op_e                  operation;
    logic [1:0]           list_select;
    logic [ITEM_BITS-1:0] payload_in;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [SLOT_OUT_BITS-1:0] slot_used;
    logic [ITEM_BITS-1:0]     payload_out;
    logic                     list_now_empty;
  } rsp_t;

  // control from the list logic to the payload store and result register
  typedef struct packed {
    status_e status;
    logic    list_empty;
    logic    mem_we;
    logic    mem_re;
  } lst_res_t;

  // selector reduced modulo the list count, sel is at most 3
  function automatic logic [1:0] sel_wrap(input logic [1:0] sel, input int unsigned count);
    logic [2:0] v;
    v = {1'b0, sel};
    for (int k = 0; k < 3; k++) begin
      if (32'(v) >= count) begin
        v = 3'(32'(v) - count);
      end
    end
    return v[1:0];
  endfunction

endpackage

// ----- hdl/spsq_pay_mem.sv -----
// payload store: one word per pool slot, one write and one registered read a cycle
// no package dependencies
module spsq_pay_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32,
  parameter int unsigned AW    = 4
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/spsq_lists.sv -----
// link table, free list and list pointers; applies one operation per fire
// depends on spsq_pkg
module spsq_lists #(
  parameter int unsigned POOL_SLOTS = 16,
  parameter int unsigned NUM_STACKS = 4,
  parameter int unsigned NUM_QUEUES = 4,
  parameter int unsigned PTR_W      = 5
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  spsq_pkg::req_t    item,
  output spsq_pkg::lst_res_t res,
  output logic [PTR_W-1:0]  slot
);

  localparam int unsigned SLOT_W = $clog2(POOL_SLOTS);
  localparam int unsigned STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int unsigned QUE_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [PTR_W-1:0] NIL  = PTR_W'(POOL_SLOTS);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(POOL_SLOTS - 1);

  logic [PTR_W-1:0] slot_next [POOL_SLOTS];
  logic [PTR_W-1:0] free_head;
  logic [PTR_W-1:0] fresh_cnt;
  logic [PTR_W-1:0] stack_top [NUM_STACKS];
  logic [PTR_W-1:0] queue_head [NUM_QUEUES];
  logic [PTR_W-1:0] queue_tail [NUM_QUEUES];

  logic [STK_W-1:0] stk;
  logic [QUE_W-1:0] que;
  logic [PTR_W-1:0] top_cur, hd, tl, rd_ptr, link, take_next;
  logic [PTR_W-1:0] free_head_next, fresh_cnt_next, top_next, hd_next, tl_next;
  logic             free_avail, fresh_take, stk_op;
  logic             nx_we;
  logic [PTR_W-1:0] nx_addr, nx_data;

  always_comb begin
    stk = STK_W'(spsq_pkg::sel_wrap(item.list_select, NUM_STACKS));
    que = QUE_W'(spsq_pkg::sel_wrap(item.list_select, NUM_QUEUES));
    top_cur = stack_top[stk];
    hd = queue_head[que];
    tl = queue_tail[que];
    stk_op = (item.operation == spsq_pkg::OP_PUSH) || (item.operation == spsq_pkg::OP_POP);

    unique case (item.operation)
      spsq_pkg::OP_POP: rd_ptr = top_cur;
      spsq_pkg::OP_DEQ: rd_ptr = hd;
      default:          rd_ptr = free_head;
    endcase
    link = slot_next[rd_ptr[SLOT_W-1:0]];

    free_avail = free_head < NIL;
    fresh_take = free_head < fresh_cnt;
    if (fresh_take) begin
      take_next = (free_head == '0) ? NIL : free_head - PTR_W'(1);
    end else begin
      take_next = link;
    end

    free_head_next = free_head;
    fresh_cnt_next = fresh_cnt;
    top_next = top_cur;
    hd_next = hd;
    tl_next = tl;
    nx_we = 1'b0;
    nx_addr = free_head;
    nx_data = top_cur;
    res.status = spsq_pkg::ST_DONE;
    res.mem_we = 1'b0;
    res.mem_re = 1'b0;
    slot = '0;

    unique case (item.operation)
      spsq_pkg::OP_PUSH: begin
        if (!free_avail) begin
          res.status = spsq_pkg::ST_FULL;
        end else begin
          free_head_next = take_next;
          if (fresh_take) begin
            fresh_cnt_next = fresh_cnt - PTR_W'(1);
          end
          nx_we = 1'b1;
          nx_addr = free_head;
          nx_data = top_cur;
          top_next = free_head;
          res.mem_we = 1'b1;
          slot = free_head;
        end
      end
      spsq_pkg::OP_POP: begin
        if (!(top_cur < NIL)) begin
          res.status = spsq_pkg::ST_EMPTY;
        end else begin
          top_next = link;
          nx_we = 1'b1;
          nx_addr = top_cur;
          nx_data = free_head;
          free_head_next = top_cur;
          res.mem_re = 1'b1;
          slot = top_cur;
        end
      end
      spsq_pkg::OP_ENQ: begin
        if (!free_avail) begin
          res.status = spsq_pkg::ST_FULL;
        end else begin
          free_head_next = take_next;
          if (fresh_take) begin
            fresh_cnt_next = fresh_cnt - PTR_W'(1);
          end
          if ((hd < NIL) && (tl < NIL)) begin
            nx_we = 1'b1;
            nx_addr = tl;
            nx_data = free_head;
          end else begin
            hd_next = free_head;
          end
          tl_next = free_head;
          res.mem_we = 1'b1;
          slot = free_head;
        end
      end
      spsq_pkg::OP_DEQ: begin
        if (!(hd < NIL) || !(tl < NIL)) begin
          res.status = spsq_pkg::ST_EMPTY;
        end else begin
          if (hd == tl) begin
            hd_next = NIL;
            tl_next = NIL;
          end else begin
            hd_next = link;
          end
          nx_we = 1'b1;
          nx_addr = hd;
          nx_data = free_head;
          free_head_next = hd;
          res.mem_re = 1'b1;
          slot = hd;
        end
      end
    endcase

    if (stk_op) begin
      res.list_empty = !(top_next < NIL);
    end else begin
      res.list_empty = !(hd_next < NIL) || !(tl_next < NIL);
    end
  end

  always_ff @(posedge clk) begin
    if (fire && nx_we) begin
      slot_next[nx_addr[SLOT_W-1:0]] <= nx_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= LAST;
      fresh_cnt <= PTR_W'(POOL_SLOTS);
      for (int i = 0; i < NUM_STACKS; i++) begin
        stack_top[i] <= NIL;
      end
      for (int i = 0; i < NUM_QUEUES; i++) begin
        queue_head[i] <= NIL;
        queue_tail[i] <= NIL;
      end
    end else if (fire) begin
      free_head <= free_head_next;
      fresh_cnt <= fresh_cnt_next;
      if (stk_op) begin
        stack_top[stk] <= top_next;
      end else begin
        queue_head[que] <= hd_next;
        queue_tail[que] <= tl_next;
      end
    end
  end

  // never-used slots sit below fresh_cnt, and the free head is the top one of them
  a_fresh_top: assert property (@(posedge clk) disable iff (rst)
    (free_head < fresh_cnt) |-> (free_head == fresh_cnt - PTR_W'(1)))
    else $error("free head inside fresh region but not its top");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    (fresh_cnt <= NIL) && (free_head <= NIL))
    else $error("free list pointer or fresh count out of range");

  a_queue_pair: assert property (@(posedge clk) disable iff (rst)
    fire |-> ((hd < NIL) == (tl < NIL)))
    else $error("queue head and tail disagree on emptiness");

  a_freed_is_head: assert property (@(posedge clk) disable iff (rst)
    fire && res.mem_re |=> (free_head == $past(slot)))
    else $error("released slot did not become free head");

  a_full_only_when_empty_pool: assert property (@(posedge clk) disable iff (rst)
    fire && (res.status == spsq_pkg::ST_FULL) |=> (free_head == NIL))
    else $error("pool full reported with free slots left");

endmodule

// ----- hdl/shared_pool_stack_queue_manager.sv -----
// top level of the shared pool stack and queue manager
// depends on spsq_pkg, spsq_lists and spsq_pay_mem
//
// One pool of POOL_SLOTS linked slots holds NUM_STACKS stacks and NUM_QUEUES
// queues. A request transaction on req carries an operation (push, pop,
// enqueue, dequeue), a list selector and a payload word; each request gives
// exactly one response transaction on rsp with status, slot, removed payload
// and the emptiness of the targeted list afterward.
// Both channels use valid and ready. A request is captured in an input
// register, applied to the pointer state when the output register can take
// its response, and that response is loaded there, raising rsp_valid. One
// request is taken per cycle while the response is not stalled; the pointer
// update and the single link table read per operation are combinational.
// If the receiver stalls, the response waits in the output register and one
// more request can wait in the input register; req_ready then drops.
// Reset is synchronous: all lists come up empty and every slot is free,
// with no clearing pass. Payload words are read only from written slots.
module shared_pool_stack_queue_manager #(
  parameter int unsigned POOL_SLOTS   = 16,
  parameter int unsigned NUM_STACKS   = 4,
  parameter int unsigned NUM_QUEUES   = 4,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  spsq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output spsq_pkg::rsp_t rsp
);

  localparam int unsigned PTR_W   = $clog2(POOL_SLOTS + 1);
  localparam int unsigned SLOT_W  = $clog2(POOL_SLOTS);
  localparam int unsigned STORE_W = (PAYLOAD_BITS < spsq_pkg::ITEM_BITS) ?
                                    PAYLOAD_BITS : spsq_pkg::ITEM_BITS;

  logic               item_valid;
  spsq_pkg::req_t     item;
  logic               fire;
  spsq_pkg::lst_res_t res;
  logic [PTR_W-1:0]   slot;
  logic [STORE_W-1:0] rd_data;

  spsq_pkg::status_e                  status_q;
  logic [spsq_pkg::SLOT_OUT_BITS-1:0] slot_q;
  logic                               empty_q;
  logic                               popped_q;

  assign fire = item_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !item_valid || fire;

  spsq_lists #(
    .POOL_SLOTS (POOL_SLOTS),
    .NUM_STACKS (NUM_STACKS),
    .NUM_QUEUES (NUM_QUEUES),
    .PTR_W      (PTR_W)
  ) u_lists (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .res  (res),
    .slot (slot)
  );

  spsq_pay_mem #(
    .DEPTH (POOL_SLOTS),
    .WIDTH (STORE_W),
    .AW    (SLOT_W)
  ) u_pay_mem (
    .clk   (clk),
    .we    (fire && res.mem_we),
    .waddr (slot[SLOT_W-1:0]),
    .wdata (item.payload_in[STORE_W-1:0]),
    .re    (fire && res.mem_re),
    .raddr (slot[SLOT_W-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        item_valid <= 1'b1;
      end else if (fire) begin
        item_valid <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (req_valid && req_ready) begin
      item <= req;
    end
    if (fire) begin
      status_q <= res.status;
      slot_q <= spsq_pkg::SLOT_OUT_BITS'(slot);
      empty_q <= res.list_empty;
      popped_q <= res.mem_re;
    end
  end

  always_comb begin
    rsp.status = status_q;
    rsp.slot_used = slot_q;
    rsp.payload_out = popped_q ? spsq_pkg::ITEM_BITS'(rd_data) : '0;
    rsp.list_now_empty = empty_q;
  end

endmodule
